[hdl/mjg_pkg.sv]
// ----------------------------------------------------------------------------
// mjg_pkg
// Shared codes, defaults and helpers for the merge-join group matcher.
// ----------------------------------------------------------------------------
package mjg_pkg;

	// default sizes
	localparam int GROUP_DEPTH_DEF  = 16;
	localparam int KEY_BITS_DEF     = 32;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int CMDQ_DEPTH       = 4;

	// input action codes
	localparam logic [1:0] ACT_RIGHT = 2'd0;
	localparam logic [1:0] ACT_LEFT  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// result kind codes
	localparam logic [1:0] KIND_PAIR    = 2'd0;
	localparam logic [1:0] KIND_NOMATCH = 2'd1;
	localparam logic [1:0] KIND_STORED  = 2'd2;
	localparam logic [1:0] KIND_DROPPED = 2'd3;

	// back end status seen by the front end
	typedef struct packed {
		logic join_busy;   // a join run sits at the queue head
		logic join_done;   // the last read of a join run issues this cycle
	} mjg_bstat_t;

	// index width for a store of the given depth
	function automatic int idx_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

[hdl/mjg_ram.sv]
// ----------------------------------------------------------------------------
// mjg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mjg_ram import mjg_pkg::*; #(
	parameter  int WIDTH = PAYLOAD_BITS_DEF,
	parameter  int DEPTH = GROUP_DEPTH_DEF,
	localparam int AW    = idx_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, hold data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/mjg_cmdq.sv]
// ----------------------------------------------------------------------------
// mjg_cmdq
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module mjg_cmdq import mjg_pkg::*; #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = CMDQ_DEPTH,
	localparam int PW    = idx_bits(DEPTH),
	localparam int NW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rptr_q];

	// store a beat
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

[hdl/mjg_front.sv]
// ----------------------------------------------------------------------------
// mjg_front
// Accepts tuples, tracks the current right group and writes its payloads,
// and turns each right or left tuple into one command for the back end.
// ----------------------------------------------------------------------------
module mjg_front import mjg_pkg::*; #(
	parameter  int GROUP_DEPTH  = GROUP_DEPTH_DEF,
	parameter  int KEY_BITS     = KEY_BITS_DEF,
	parameter  int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int AW           = idx_bits(GROUP_DEPTH),
	localparam int CW           = $clog2(GROUP_DEPTH + 1),
	localparam int PNW          = $clog2(CMDQ_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// tuple input
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              action,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	// command output
	output logic                    cmd_push,
	input  logic                    cmd_full,
	output logic [1:0]              cmd_kind,
	output logic [KEY_BITS-1:0]     cmd_key,
	output logic [PAYLOAD_BITS-1:0] cmd_lp,
	output logic [PAYLOAD_BITS-1:0] cmd_rp,
	output logic [CW-1:0]           cmd_count,
	// group store write port
	output logic                    ram_we,
	output logic [AW-1:0]           ram_waddr,
	output logic [PAYLOAD_BITS-1:0] ram_wdata,
	// back end status
	input  mjg_bstat_t              bstat
);

	logic [KEY_BITS-1:0] grp_key_q;
	logic                grp_valid_q;
	logic [CW-1:0]       grp_cnt_q;
	logic [PNW-1:0]      pend_q;

	logic          same_grp;
	logic          restart;
	logic          hazard;
	logic          take;
	logic [CW-1:0] cnt_eff;
	logic          room;
	logic          pair_push;

	// classify against the held group
	assign same_grp = grp_valid_q && (key == grp_key_q);
	assign restart  = !same_grp;
	assign cnt_eff  = restart ? '0 : grp_cnt_q;
	assign room     = (cnt_eff < CW'(GROUP_DEPTH));

	// a new group overwrites entry zero: hold it while a join still reads
	assign hazard = (action == ACT_RIGHT) && restart && (pend_q != '0);
	assign full   = cmd_full || hazard;
	assign take   = push && !full;

	// build the command
	always_comb begin
		cmd_push  = 1'b0;
		cmd_kind  = KIND_NOMATCH;
		cmd_key   = key;
		cmd_lp    = '0;
		cmd_rp    = '0;
		cmd_count = grp_cnt_q;
		unique case (action)
			ACT_RIGHT: begin
				cmd_push = take;
				cmd_kind = room ? KIND_STORED : KIND_DROPPED;
				cmd_rp   = payload;
			end
			ACT_LEFT: begin
				cmd_push = take;
				if (same_grp && (grp_cnt_q != '0)) begin
					cmd_kind = KIND_PAIR;
					cmd_lp   = payload;
				end
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	assign pair_push = cmd_push && (cmd_kind == KIND_PAIR);

	// append to the group store
	assign ram_we    = take && (action == ACT_RIGHT) && room;
	assign ram_waddr = cnt_eff[AW-1:0];
	assign ram_wdata = payload;

	// update group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_key_q   <= '0;
			grp_valid_q <= 1'b0;
			grp_cnt_q   <= '0;
		end else if (take) begin
			if (action == ACT_RIGHT) begin
				grp_key_q   <= key;
				grp_valid_q <= 1'b1;
				grp_cnt_q   <= cnt_eff + CW'(room);
			end else if (action == ACT_CLEAR) begin
				grp_key_q   <= '0;
				grp_valid_q <= 1'b0;
				grp_cnt_q   <= '0;
			end
		end
	end

	// count join runs not yet fully read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pair_push && !bstat.join_done) begin
			pend_q <= pend_q + PNW'(1);
		end else if (bstat.join_done && !pair_push) begin
			pend_q <= pend_q - PNW'(1);
		end
	end

endmodule

[hdl/mjg_back.sv]
// ----------------------------------------------------------------------------
// mjg_back
// Executes commands: one result beat per command, or one joined pair per
// buffered right tuple, read one store entry a cycle unless output stalls.
// ----------------------------------------------------------------------------
module mjg_back import mjg_pkg::*; #(
	parameter  int GROUP_DEPTH  = GROUP_DEPTH_DEF,
	parameter  int KEY_BITS     = KEY_BITS_DEF,
	parameter  int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int AW           = idx_bits(GROUP_DEPTH),
	localparam int CW           = $clog2(GROUP_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command input
	input  logic                    cmd_empty,
	output logic                    cmd_pop,
	input  logic [1:0]              cmd_kind,
	input  logic [KEY_BITS-1:0]     cmd_key,
	input  logic [PAYLOAD_BITS-1:0] cmd_lp,
	input  logic [PAYLOAD_BITS-1:0] cmd_rp,
	input  logic [CW-1:0]           cmd_count,
	// group store read port
	output logic                    ram_re,
	output logic [AW-1:0]           ram_raddr,
	input  logic [PAYLOAD_BITS-1:0] ram_rdata,
	output mjg_bstat_t              bstat,
	// result output
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              kind,
	output logic [PAYLOAD_BITS-1:0] left_payload,
	output logic [PAYLOAD_BITS-1:0] right_payload,
	output logic [KEY_BITS-1:0]     match_key,
	output logic                    last
);

	logic [CW-1:0]           idx_q;
	logic                    v_s1;
	logic [1:0]              kind_s1;
	logic [KEY_BITS-1:0]     key_s1;
	logic [PAYLOAD_BITS-1:0] lp_s1;
	logic [PAYLOAD_BITS-1:0] rp_s1;
	logic                    last_s1;
	logic                    use_ram_s1;
	logic                    out_v_q;
	logic [1:0]              kind_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] lp_q;
	logic [PAYLOAD_BITS-1:0] rp_q;
	logic                    last_q;

	logic head_pair;
	logic out_rdy;
	logic adv_s1;
	logic issue;
	logic is_last;

	// sequencing
	assign head_pair = !cmd_empty && (cmd_kind == KIND_PAIR);
	assign out_rdy   = !out_v_q || pop;
	assign adv_s1    = v_s1 && out_rdy;
	assign issue     = !cmd_empty && (!v_s1 || out_rdy);
	assign is_last   = !head_pair || ((idx_q + CW'(1)) == cmd_count);
	assign cmd_pop   = issue && is_last;

	assign ram_re    = issue && head_pair;
	assign ram_raddr = idx_q[AW-1:0];

	assign bstat.join_busy = head_pair;
	assign bstat.join_done = cmd_pop && head_pair;

	// walk the group entries of a join run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= is_last ? '0 : idx_q + CW'(1);
		end
	end

	// read stage: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// read stage: beat fields
	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1    <= cmd_kind;
			key_s1     <= cmd_key;
			lp_s1      <= cmd_lp;
			rp_s1      <= cmd_rp;
			last_s1    <= is_last;
			use_ram_s1 <= head_pair;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// output register: beat fields, pair payload from the store
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_q <= kind_s1;
			key_q  <= key_s1;
			lp_q   <= lp_s1;
			rp_q   <= use_ram_s1 ? ram_rdata : rp_s1;
			last_q <= last_s1;
		end
	end

	assign empty         = !out_v_q;
	assign kind          = kind_q;
	assign left_payload  = lp_q;
	assign right_payload = rp_q;
	assign match_key     = key_q;
	assign last          = last_q;

endmodule

[hdl/merge_join_group_matcher.sv]
// ----------------------------------------------------------------------------
// merge_join_group_matcher
// Equi-join stage of a sort-merge join over one merged, key-sorted stream.
// ----------------------------------------------------------------------------
// The front end takes one tuple per cycle while full is low: a right tuple
// is stored in the group buffer (or dropped when it is full) and gives one
// result, a left tuple without a match gives one result, and a clear gives
// none. A left tuple that matches the held group gives one joined pair per
// buffered right tuple, read from the group RAM at one entry per cycle
// unless the output stalls. A four entry command queue separates the two
// ends; a right tuple that starts a new group waits while a join run is
// still reading the buffer. An item passes the command queue, the read
// stage and the output register before its first result appears.
// ----------------------------------------------------------------------------
module merge_join_group_matcher import mjg_pkg::*; #(
	parameter int GROUP_DEPTH  = GROUP_DEPTH_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// tuple input
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              action,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	// result output
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              kind,
	output logic [PAYLOAD_BITS-1:0] left_payload,
	output logic [PAYLOAD_BITS-1:0] right_payload,
	output logic [KEY_BITS-1:0]     match_key,
	output logic                    last
);

	localparam int AW = idx_bits(GROUP_DEPTH);
	localparam int CW = $clog2(GROUP_DEPTH + 1);
	localparam int QW = 2 + KEY_BITS + 2 * PAYLOAD_BITS + CW;

	logic                    f_push;
	logic [1:0]              f_kind;
	logic [KEY_BITS-1:0]     f_key;
	logic [PAYLOAD_BITS-1:0] f_lp;
	logic [PAYLOAD_BITS-1:0] f_rp;
	logic [CW-1:0]           f_count;
	logic                    b_pop;
	logic [1:0]              b_kind;
	logic [KEY_BITS-1:0]     b_key;
	logic [PAYLOAD_BITS-1:0] b_lp;
	logic [PAYLOAD_BITS-1:0] b_rp;
	logic [CW-1:0]           b_count;
	logic [QW-1:0]           q_wdata;
	logic [QW-1:0]           q_rdata;
	logic                    q_full;
	logic                    q_empty;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [PAYLOAD_BITS-1:0] ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [PAYLOAD_BITS-1:0] ram_rdata;
	mjg_bstat_t              bstat;

	// front end
	mjg_front #(
		.GROUP_DEPTH  (GROUP_DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.key       (key),
		.payload   (payload),
		.cmd_push  (f_push),
		.cmd_full  (q_full),
		.cmd_kind  (f_kind),
		.cmd_key   (f_key),
		.cmd_lp    (f_lp),
		.cmd_rp    (f_rp),
		.cmd_count (f_count),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.bstat     (bstat)
	);

	// command queue
	assign q_wdata = {f_kind, f_key, f_lp, f_rp, f_count};
	assign {b_kind, b_key, b_lp, b_rp, b_count} = q_rdata;

	mjg_cmdq #(
		.WIDTH (QW),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (q_wdata),
		.rd     (b_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// group store
	mjg_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (GROUP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back end
	mjg_back #(
		.GROUP_DEPTH  (GROUP_DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (q_empty),
		.cmd_pop       (b_pop),
		.cmd_kind      (b_kind),
		.cmd_key       (b_key),
		.cmd_lp        (b_lp),
		.cmd_rp        (b_rp),
		.cmd_count     (b_count),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.bstat         (bstat),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.left_payload  (left_payload),
		.right_payload (right_payload),
		.match_key     (match_key),
		.last          (last)
	);

`ifndef SYNTHESIS
	// never write a command into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("command queue overflow");

	// never take a command from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |-> !q_empty)
		else $error("command queue underflow");

	// a new group must not overwrite the buffer under a running join
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (ram_waddr == '0)) |-> !bstat.join_busy)
		else $error("group buffer restarted during a join run");
`endif

endmodule

[verif/merge_join_group_matcher_tb.sv]
// ----------------------------------------------------------------------------
// merge_join_group_matcher_tb
// Self-checking bench for the equi-join group matcher.
// ----------------------------------------------------------------------------
// A short table of directed beats covers reset state, key extremes, group
// overflow, clears and the unused action code. Random key-sorted runs of
// right tuples followed by left tuples come next, mixed with noise. Every
// accepted beat runs through a local group model, and each popped result is
// compared field by field with the oldest pending one. Push and pop both
// idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module merge_join_group_matcher_tb;
	import mjg_pkg::*;

	localparam int         KW          = KEY_BITS_DEF;
	localparam int         PW          = PAYLOAD_BITS_DEF;
	localparam int         DEPTH       = GROUP_DEPTH_DEF;
	localparam int         TBL_ROWS    = 20;
	localparam int         ITEM_TARGET = 120;
	localparam int         STALL_MAX   = 2000;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	typedef struct packed {
		logic [1:0]    kind;
		logic [PW-1:0] left_payload;
		logic [PW-1:0] right_payload;
		logic [KW-1:0] match_key;
		logic          last;
	} result_t;

	typedef struct packed {
		logic [1:0]    act;
		logic [KW-1:0] key;
		logic [PW-1:0] pay;
		logic [4:0]    reps;
		logic          typed;
		result_t       want;
	} stim_row_t;

	logic          clk     = 1'b0;
	logic          arst_n  = 1'b0;
	logic          push    = 1'b0;
	logic [1:0]    action  = ACT_RIGHT;
	logic [KW-1:0] key     = '0;
	logic [PW-1:0] payload = '0;
	logic          pop     = 1'b0;
	logic          full;
	logic          empty;
	logic [1:0]    kind;
	logic [PW-1:0] left_payload;
	logic [PW-1:0] right_payload;
	logic [KW-1:0] match_key;
	logic          last;

	// group model state
	logic [KW-1:0] grp_key;
	logic          grp_valid;
	int unsigned   grp_count;
	logic [PW-1:0] grp_store [DEPTH];
	result_t       step_res  [DEPTH];

	result_t   pending_results [$];
	result_t   head_res;
	stim_row_t stim_tbl [TBL_ROWS];
	int        mismatches  = 0;
	int        beats_sent  = 0;
	int        stall_count = 0;
	int        pop_wait    = 0;
	logic      calm        = 1'b0;

	merge_join_group_matcher #(
		.GROUP_DEPTH  (DEPTH),
		.KEY_BITS     (KW),
		.PAYLOAD_BITS (PW)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.key           (key),
		.payload       (payload),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.left_payload  (left_payload),
		.right_payload (right_payload),
		.match_key     (match_key),
		.last          (last)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// queue one expected result behind the others
	function automatic void queue_expected(input result_t r);
		pending_results = {pending_results, r};
	endfunction

	// advance the group model by one beat, return the number of results
	function automatic int predict_join(input logic [1:0] act, input logic [KW-1:0] k,
		input logic [PW-1:0] p);
		int n;
		n = 0;
		case (act)
			ACT_RIGHT: begin
				if (!(grp_valid && k == grp_key)) begin
					grp_key   = k;
					grp_valid = 1'b1;
					grp_count = 0;
				end
				if (grp_count < DEPTH) begin
					grp_store[grp_count] = p;
					grp_count++;
					step_res[0] = {KIND_STORED, {PW{1'b0}}, p, k, 1'b1};
				end else begin
					step_res[0] = {KIND_DROPPED, {PW{1'b0}}, p, k, 1'b1};
				end
				n = 1;
			end
			ACT_LEFT: begin
				if (grp_valid && k == grp_key && grp_count > 0) begin
					for (int i = 0; i < grp_count; i++)
						step_res[i] = {KIND_PAIR, p, grp_store[i], k, i == grp_count - 1};
					n = grp_count;
				end else begin
					step_res[0] = {KIND_NOMATCH, {PW{1'b0}}, {PW{1'b0}}, k, 1'b1};
					n = 1;
				end
			end
			ACT_CLEAR: begin
				grp_key   = '0;
				grp_valid = 1'b0;
				grp_count = 0;
			end
			default: ;
		endcase
		return n;
	endfunction

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// drive one beat, wait for it to be taken, queue what it should produce
	task automatic send_beat(input logic [1:0] act, input logic [KW-1:0] k,
		input logic [PW-1:0] p, input logic typed, input result_t want);
		int n;
		int g;
		action  <= act;
		key     <= k;
		payload <= p;
		push    <= 1'b1;
		do @(posedge clk); while (full);
		n = predict_join(act, k, p);
		if (typed)
			queue_expected(want);
		else
			for (int i = 0; i < n; i++)
				queue_expected(step_res[i]);
		if (act != ACT_UNUSED)
			beats_sent++;
		g = pick_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// hold the sender until every pending result has been popped
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// compare the popped beat with the oldest pending result
	task automatic compare_result();
		if (pending_results.size() == 0) begin
			$error("unexpected result: kind %0d key %h", kind, match_key);
			mismatches++;
		end else begin
			head_res = pending_results.pop_front();
			if (kind !== head_res.kind) begin
				$error("kind: expected %0d, got %0d", head_res.kind, kind);
				mismatches++;
			end
			if (left_payload !== head_res.left_payload) begin
				$error("left_payload: expected %h, got %h", head_res.left_payload,
					left_payload);
				mismatches++;
			end
			if (right_payload !== head_res.right_payload) begin
				$error("right_payload: expected %h, got %h", head_res.right_payload,
					right_payload);
				mismatches++;
			end
			if (match_key !== head_res.match_key) begin
				$error("match_key: expected %h, got %h", head_res.match_key, match_key);
				mismatches++;
			end
			if (last !== head_res.last) begin
				$error("last: expected %0d, got %0d", head_res.last, last);
				mismatches++;
			end
		end
	endtask

	// check popped beats and stall pop at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				compare_result();
			if (pop_wait > 0) begin
				pop <= 1'b0;
				pop_wait--;
			end else begin
				pop <= 1'b1;
				pop_wait = pick_gap();
			end
		end
	end

	// end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_MAX) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int            r;
		int            nr;
		int            nl;
		logic          drained_mid;
		logic [KW-1:0] k;
		logic [KW-1:0] next_key;

		// directed rows: typed results where they are obvious, model elsewhere
		stim_tbl[0]  = '{ACT_LEFT, 32'h0, 32'h0, 5'd1, 1'b1,
			{KIND_NOMATCH, 32'h0, 32'h0, 32'h0, 1'b1}};
		stim_tbl[1]  = '{ACT_RIGHT, 32'h0, 32'hFFFF_FFFF, 5'd1, 1'b1,
			{KIND_STORED, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1}};
		stim_tbl[2]  = '{ACT_LEFT, 32'h0, 32'h1234_5678, 5'd1, 1'b1,
			{KIND_PAIR, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 1'b1}};
		stim_tbl[3]  = '{ACT_LEFT, 32'h1, 32'hFFFF_FFFF, 5'd1, 1'b1,
			{KIND_NOMATCH, 32'h0, 32'h0, 32'h1, 1'b1}};
		stim_tbl[4]  = '{ACT_CLEAR, 32'h0, 32'h0, 5'd1, 1'b0, '0};
		stim_tbl[5]  = '{ACT_LEFT, 32'h0, 32'hCAFE_F00D, 5'd1, 1'b1,
			{KIND_NOMATCH, 32'h0, 32'h0, 32'h0, 1'b1}};
		stim_tbl[6]  = '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, '0};
		stim_tbl[7]  = '{ACT_RIGHT, 32'hFFFF_FFFF, 32'h0, 5'd16, 1'b0, '0};
		stim_tbl[8]  = '{ACT_RIGHT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 5'd1, 1'b1,
			{KIND_DROPPED, 32'h0, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b1}};
		stim_tbl[9]  = '{ACT_LEFT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 5'd1, 1'b0, '0};
		stim_tbl[10] = '{ACT_LEFT, 32'hFFFF_FFFE, 32'h0, 5'd1, 1'b1,
			{KIND_NOMATCH, 32'h0, 32'h0, 32'hFFFF_FFFE, 1'b1}};
		stim_tbl[11] = '{ACT_RIGHT, 32'h8000_0000, 32'hDEAD_BEEF, 5'd1, 1'b1,
			{KIND_STORED, 32'h0, 32'hDEAD_BEEF, 32'h8000_0000, 1'b1}};
		stim_tbl[12] = '{ACT_LEFT, 32'h7FFF_FFFF, 32'h1, 5'd1, 1'b1,
			{KIND_NOMATCH, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1}};
		stim_tbl[13] = '{ACT_LEFT, 32'h8000_0000, 32'hFFFF_FFFF, 5'd1, 1'b1,
			{KIND_PAIR, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h8000_0000, 1'b1}};
		stim_tbl[14] = '{ACT_RIGHT, 32'h8000_0000, 32'h2, 5'd1, 1'b0, '0};
		stim_tbl[15] = '{ACT_LEFT, 32'h8000_0000, 32'h3, 5'd1, 1'b0, '0};
		stim_tbl[16] = '{ACT_CLEAR, 32'h0, 32'h0, 5'd1, 1'b0, '0};
		stim_tbl[17] = '{ACT_RIGHT, 32'h8000_0000, 32'h4, 5'd1, 1'b1,
			{KIND_STORED, 32'h0, 32'h4, 32'h8000_0000, 1'b1}};
		stim_tbl[18] = '{ACT_LEFT, 32'h8000_0000, 32'h5, 5'd1, 1'b1,
			{KIND_PAIR, 32'h5, 32'h4, 32'h8000_0000, 1'b1}};
		stim_tbl[19] = '{ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, '0};

		// model reset state
		grp_key     = '0;
		grp_valid   = 1'b0;
		grp_count   = 0;
		drained_mid = 1'b0;
		next_key    = $urandom_range(0, 1000);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; repeated rows step the payload
		for (int t = 0; t < TBL_ROWS; t++)
			for (int j = 0; j < stim_tbl[t].reps; j++)
				send_beat(stim_tbl[t].act, stim_tbl[t].key, stim_tbl[t].pay + j,
					stim_tbl[t].typed, stim_tbl[t].want);
		wait_drained();

		// random key-sorted groups with noise in between, up to the item target
		while (beats_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				k        = ($urandom_range(0, 9) == 0) ? $urandom : next_key;
				next_key = next_key + $urandom_range(1, 1000);
				nr       = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
				                                       : $urandom_range(1, 4);
				nl       = $urandom_range(1, 3);
				for (int i = 0; i < nr; i++)
					send_beat(ACT_RIGHT, k, $urandom, 1'b0, '0);
				for (int i = 0; i < nl; i++)
					send_beat(ACT_LEFT, k, $urandom, 1'b0, '0);
				if ($urandom_range(0, 3) == 0)
					send_beat(ACT_LEFT, k + 1, $urandom, 1'b0, '0);
			end else begin
				k = $urandom_range(0, 1) ? grp_key : $urandom;
				send_beat(2'($urandom_range(0, 3)), k, $urandom, 1'b0, '0);
			end
			// one mid-run hold until the result side has caught up
			if (!drained_mid && beats_sent >= ITEM_TARGET / 2) begin
				drained_mid = 1'b1;
				wait_drained();
			end
		end
		calm = 1'b0;

		// drain, then let trailing results show up
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
